[rtl/core/spmb_pkg.sv]
// shared types, constants and helpers for the stepper position move block
`default_nettype none
package spmb_pkg;

  localparam int unsigned POS_BITS    = 12;
  localparam int unsigned BL_BITS     = 8;
  localparam int unsigned PERIOD_BITS = 16;
  localparam int unsigned CFG_DATA_BITS = 16;
  localparam int unsigned CFG_IDX_BITS  = 2;
  localparam int unsigned TABLE_ROW   = 0;

  // register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_LOW_LIMIT  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_HIGH_LIMIT = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_BACKLASH   = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_PERIOD     = 2'd3;

  // register reset values
  localparam logic [POS_BITS-1:0]    LOW_LIMIT_RST  = POS_BITS'(0);
  localparam logic [POS_BITS-1:0]    HIGH_LIMIT_RST = POS_BITS'(1000);
  localparam logic [BL_BITS-1:0]     BACKLASH_RST   = BL_BITS'(8);
  localparam logic [PERIOD_BITS-1:0] PERIOD_RST     = PERIOD_BITS'(10);
  localparam logic [POS_BITS-1:0]    POSITION_RST   = POS_BITS'(500);

  // direction codes
  localparam logic [1:0] DIR_NONE = 2'b00;
  localparam logic [1:0] DIR_UP   = 2'b01;
  localparam logic [1:0] DIR_DOWN = 2'b11;

  // half-step coil patterns, two winding orders
  localparam logic [3:0] COIL_TABLE [2][8] = '{
    '{4'd1, 4'd3, 4'd2, 4'd6, 4'd4, 4'd12, 4'd8, 4'd9},
    '{4'd8, 4'd12, 4'd4, 4'd6, 4'd2, 4'd3, 4'd1, 4'd9}
  };

  typedef struct packed {
    logic [POS_BITS-1:0]    low_limit;
    logic [POS_BITS-1:0]    high_limit;
    logic [BL_BITS-1:0]     backlash;
    logic [PERIOD_BITS-1:0] period;
  } cfg_t;

  typedef struct packed {
    logic [3:0]          coils;
    logic                busy_res;
    logic [POS_BITS-1:0] position;
  } res_t;

  function automatic logic [POS_BITS-1:0] pos_step(input logic [POS_BITS-1:0] v,
                                                   input logic [1:0] dir);
    logic [POS_BITS-1:0] r;
    r = v;
    if (dir == DIR_UP) begin
      r = v + POS_BITS'(1);
    end else if (dir == DIR_DOWN) begin
      r = v - POS_BITS'(1);
    end
    return r;
  endfunction

  function automatic logic [2:0] phase_step(input logic [2:0] v, input logic [1:0] dir);
    logic [2:0] r;
    r = v;
    if (dir == DIR_UP) begin
      r = v + 3'd1;
    end else if (dir == DIR_DOWN) begin
      r = v - 3'd1;
    end
    return r;
  endfunction

  function automatic logic [1:0] dir_neg(input logic [1:0] dir);
    logic [1:0] r;
    r = DIR_NONE;
    if (dir == DIR_UP) begin
      r = DIR_DOWN;
    end else if (dir == DIR_DOWN) begin
      r = DIR_UP;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

[rtl/core/spmb_in_if.sv]
// input and output word channels
`default_nettype none
interface spmb_in_if;
  import spmb_pkg::*;
  logic                valid;
  logic                ready;
  logic                mode;
  logic [POS_BITS-1:0] target;

  modport source (output valid, output mode, output target, input ready);
  modport sink (input valid, input mode, input target, output ready);
endinterface

interface spmb_out_if;
  import spmb_pkg::*;
  logic                valid;
  logic                ready;
  logic [3:0]          coils;
  logic                busy_res;
  logic [POS_BITS-1:0] position;

  modport source (output valid, output coils, output busy_res, output position,
                  input ready);
  modport sink (input valid, input coils, input busy_res, input position,
                output ready);
endinterface
`default_nettype wire

[rtl/core/stepper_position_move_backlash.sv]
// top level of the half-step stepper move driver with backlash take-up
`default_nettype none
// Half-step stepper driver. Each input word is a tick of the step time base
// (mode 0) or a move command (mode 1) with a target that is clamped to the
// low/high limit registers. Every accepted word yields exactly one result
// word: coil pattern, busy flag and logical position after that word. A move
// that reverses direction first holds the phase one step period, then takes
// backlash_steps half-steps without changing position, holds again, and walks
// one half-step per step period until the target or a limit, then turns the
// coils off. Commands arriving while busy are ignored. One word is accepted
// per clock while the consumer takes results: the sequencer result is
// combinational and lands in an output register, so throughput is one word
// per cycle and the result is valid in the cycle after acceptance. Input ready
// drops only while the output register is full and the consumer is stalling.
// Configuration writes are only legal while no move is in progress.
module stepper_position_move_backlash (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [spmb_pkg::CFG_IDX_BITS-1:0]   cfg_idx_i,
  input  wire logic [spmb_pkg::CFG_DATA_BITS-1:0]  cfg_data_i,
  spmb_in_if.sink                                  in_i,
  spmb_out_if.source                               out_o
);
  import spmb_pkg::*;

  cfg_t cfg;
  res_t res;
  logic room;
  logic accept;

  // a word is taken whenever the result register can take its result
  assign in_i.ready = room;
  assign accept     = in_i.valid && room;

  // limit, backlash and period registers
  spmb_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // sequencer: move start, tick counting, backlash and walk steps
  spmb_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .accept_i (accept),
    .mode_i   (in_i.mode),
    .target_i (in_i.target),
    .res_o    (res)
  );

  // result register toward the consumer
  spmb_out u_out (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (accept),
    .res_i  (res),
    .room_o (room),
    .out_o  (out_o)
  );
endmodule
`default_nettype wire

[rtl/core/spmb_cfg.sv]
// configuration register bank
`default_nettype none
module spmb_cfg (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 cfg_we_i,
  input  wire logic [spmb_pkg::CFG_IDX_BITS-1:0]    cfg_idx_i,
  input  wire logic [spmb_pkg::CFG_DATA_BITS-1:0]   cfg_data_i,
  output spmb_pkg::cfg_t                            cfg_o
);
  import spmb_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_LOW_LIMIT:  cfg_d.low_limit  = cfg_data_i[POS_BITS-1:0];
        REG_HIGH_LIMIT: cfg_d.high_limit = cfg_data_i[POS_BITS-1:0];
        REG_BACKLASH:   cfg_d.backlash   = cfg_data_i[BL_BITS-1:0];
        REG_PERIOD:     cfg_d.period     = cfg_data_i[PERIOD_BITS-1:0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.low_limit  <= LOW_LIMIT_RST;
      cfg_q.high_limit <= HIGH_LIMIT_RST;
      cfg_q.backlash   <= BACKLASH_RST;
      cfg_q.period     <= PERIOD_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;
endmodule
`default_nettype wire

[rtl/core/spmb_seq.sv]
// move sequencer: dwell, backlash take-up and half-step walk
`default_nettype none
module spmb_seq (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire spmb_pkg::cfg_t               cfg_i,
  input  wire logic                         accept_i,
  input  wire logic                         mode_i,
  input  wire logic [spmb_pkg::POS_BITS-1:0] target_i,
  output spmb_pkg::res_t                    res_o
);
  import spmb_pkg::*;

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_DWELL_A  = 3'd1;
  localparam logic [2:0] ST_BACKLASH = 3'd2;
  localparam logic [2:0] ST_DWELL_B  = 3'd3;
  localparam logic [2:0] ST_WALK     = 3'd4;

  logic [2:0]             state_q, state_d;
  logic [POS_BITS-1:0]    pos_q, pos_d;
  logic                   last_down_q, last_down_d;
  logic [2:0]             phase_q, phase_d;
  logic [1:0]             mdir_q, mdir_d;
  logic [POS_BITS-1:0]    mtarget_q, mtarget_d;
  logic [PERIOD_BITS-1:0] tick_q, tick_d;
  logic [BL_BITS-1:0]     bcnt_q, bcnt_d;
  logic                   lim_q, lim_d;

  logic [PERIOD_BITS-1:0] period;
  logic [PERIOD_BITS-1:0] tick_inc;
  logic [POS_BITS-1:0]    clamp_hi, clamp;
  logic [1:0]             new_dir;
  logic                   at_limit;

  assign period   = (cfg_i.period == '0) ? PERIOD_BITS'(1) : cfg_i.period;
  assign tick_inc = tick_q + PERIOD_BITS'(1);
  assign clamp_hi = (target_i > cfg_i.high_limit) ? cfg_i.high_limit : target_i;
  assign clamp    = (clamp_hi < cfg_i.low_limit) ? cfg_i.low_limit : clamp_hi;
  assign new_dir  = (pos_q < clamp) ? DIR_UP : ((pos_q > clamp) ? DIR_DOWN : DIR_NONE);
  assign at_limit = (pos_q == cfg_i.high_limit) || (pos_q == cfg_i.low_limit);

  always_comb begin
    state_d     = state_q;
    pos_d       = pos_q;
    last_down_d = last_down_q;
    phase_d     = phase_q;
    mdir_d      = mdir_q;
    mtarget_d   = mtarget_q;
    tick_d      = tick_q;
    bcnt_d      = bcnt_q;
    lim_d       = lim_q;

    if (accept_i) begin
      if (state_q == ST_IDLE) begin
        if (mode_i) begin
          // start a move
          mtarget_d = clamp;
          mdir_d    = new_dir;
          tick_d    = '0;
          bcnt_d    = '0;
          lim_d     = 1'b0;
          if ((new_dir == DIR_UP && last_down_q) || (new_dir == DIR_DOWN && !last_down_q)) begin
            state_d = ST_DWELL_A;
          end else begin
            if (at_limit) begin
              lim_d = 1'b1;
              pos_d = pos_step(pos_q, new_dir);
            end
            state_d = ST_DWELL_B;
          end
          if (new_dir != DIR_NONE) begin
            last_down_d = (new_dir == DIR_DOWN);
          end
        end
      end else if (!mode_i) begin
        if (tick_inc >= period) begin
          tick_d = '0;
          case (state_q)
            ST_DWELL_A, ST_BACKLASH: begin
              if (bcnt_q < cfg_i.backlash) begin
                phase_d = phase_step(phase_q, mdir_q);
                bcnt_d  = bcnt_q + BL_BITS'(1);
                state_d = ST_BACKLASH;
              end else begin
                if (at_limit) begin
                  lim_d = 1'b1;
                  pos_d = pos_step(pos_q, mdir_q);
                end
                state_d = ST_DWELL_B;
              end
            end
            ST_DWELL_B, ST_WALK: begin
              if (pos_q != mtarget_q && pos_q < cfg_i.high_limit &&
                  pos_q > cfg_i.low_limit) begin
                phase_d = phase_step(phase_q, mdir_q);
                pos_d   = pos_step(pos_q, mdir_q);
                state_d = ST_WALK;
              end else begin
                // undo the bump taken when the move started at a limit
                if (lim_q) begin
                  pos_d = pos_step(pos_q, dir_neg(mdir_q));
                end
                lim_d   = 1'b0;
                state_d = ST_IDLE;
              end
            end
            default: state_d = ST_IDLE;
          endcase
        end else begin
          tick_d = tick_inc;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pos_q       <= POSITION_RST;
      last_down_q <= 1'b1;
      phase_q     <= '0;
      mdir_q      <= DIR_NONE;
      mtarget_q   <= '0;
      tick_q      <= '0;
      bcnt_q      <= '0;
      lim_q       <= 1'b0;
    end else begin
      state_q     <= state_d;
      pos_q       <= pos_d;
      last_down_q <= last_down_d;
      phase_q     <= phase_d;
      mdir_q      <= mdir_d;
      mtarget_q   <= mtarget_d;
      tick_q      <= tick_d;
      bcnt_q      <= bcnt_d;
      lim_q       <= lim_d;
    end
  end

  // result for this word, taken from the updated state
  always_comb begin
    res_o.busy_res = (state_d != ST_IDLE);
    res_o.coils    = (state_d != ST_IDLE) ? COIL_TABLE[TABLE_ROW][phase_d] : 4'd0;
    res_o.position = pos_d;
  end
endmodule
`default_nettype wire

[rtl/core/spmb_out.sv]
// result register with valid/ready toward the consumer
`default_nettype none
module spmb_out (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push_i,
  input  wire spmb_pkg::res_t res_i,
  output logic            room_o,
  spmb_out_if.source      out_o
);
  import spmb_pkg::*;

  logic valid_q, valid_d;
  res_t res_q;

  assign room_o  = !valid_q || out_o.ready;
  assign valid_d = push_i || (valid_q && !out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      res_q <= res_i;
    end
  end

  assign out_o.valid    = valid_q;
  assign out_o.coils    = res_q.coils;
  assign out_o.busy_res = res_q.busy_res;
  assign out_o.position = res_q.position;
endmodule
`default_nettype wire
